[hdl/mhlg_pkg.sv]
// shared types and constants of the multiclass hinge loss gradient block
package mhlg_pkg;

  localparam int SCORE_W    = 16;
  localparam int DELTA_W    = 15;
  localparam int RECIP_W    = 17;
  localparam int GRAD_W     = 24;
  localparam int CIDX_W     = 4;
  localparam int MEAN_W     = 40;
  localparam int LOSS_W     = 48;
  localparam int TSUM_W     = 24;
  localparam int MARGIN_W   = 26;
  localparam int MUL_A_W    = 32;
  localparam int PROD_W     = MUL_A_W + RECIP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_DELTA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_RECIP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_ONLY = 2'd2;

  localparam logic [DELTA_W-1:0] DELTA_RESET = 15'd51;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 17'd65536;

  typedef enum logic [1:0] {
    MUL_LO,
    MUL_HI,
    MUL_HITS
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mrg_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     mean_en;
    logic     rd_first;
    logic     emit;
    logic     fout;
    logic     clr_row;
    logic     clr_loss;
    logic     batch;
  } dp_cmd_t;

  typedef struct packed {
    logic ra_done;
    logic out_free;
    logic fwd;
  } dp_sts_t;

endpackage

[hdl/mhlg_ctrl.sv]
// sequencer: row loading, margin pass, mean loss steps, gradient emission and forward-mode loss output
module mhlg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_row_end,
  input  logic               in_batch_end,
  input  mhlg_pkg::dp_sts_t  sts,
  output mhlg_pkg::dp_cmd_t  cmd,
  output logic               in_stall
);
  import mhlg_pkg::*;

  typedef enum logic [7:0] {
    ST_LOAD = 8'b0000_0001,
    ST_MRG  = 8'b0000_0010,
    ST_MLO  = 8'b0000_0100,
    ST_MHI  = 8'b0000_1000,
    ST_MSUM = 8'b0001_0000,
    ST_GMUL = 8'b0010_0000,
    ST_EMIT = 8'b0100_0000,
    ST_FOUT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   batch_r, batch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      batch_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      batch_r <= batch_nxt;
    end
  end

  assign in_stall = (state_r != ST_LOAD);

  always_comb begin
    state_nxt = state_r;
    batch_nxt = batch_r;
    cmd       = '0;
    cmd.batch = batch_r;
    unique case (state_r)
      ST_LOAD: begin
        cmd.load = in_valid;
        // batch end closes the row as well
        if (in_valid && (in_row_end || in_batch_end)) begin
          batch_nxt = in_batch_end;
          state_nxt = ST_MRG;
        end
      end
      ST_MRG: begin
        cmd.mrg_step = 1'b1;
        if (sts.ra_done) begin
          if (batch_r) begin
            state_nxt = ST_MLO;
          end else if (sts.fwd) begin
            cmd.clr_row = 1'b1;
            state_nxt   = ST_LOAD;
          end else begin
            state_nxt = ST_GMUL;
          end
        end
      end
      ST_MLO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO;
        state_nxt   = ST_MHI;
      end
      ST_MHI: begin
        cmd.acc_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HI;
        state_nxt   = ST_MSUM;
      end
      ST_MSUM: begin
        cmd.mean_en = 1'b1;
        state_nxt   = sts.fwd ? ST_FOUT : ST_GMUL;
      end
      ST_GMUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_HITS;
        cmd.rd_first = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.ra_done) begin
            cmd.clr_row  = 1'b1;
            cmd.clr_loss = batch_r;
            state_nxt    = ST_LOAD;
          end
        end
      end
      ST_FOUT: begin
        if (sts.out_free) begin
          cmd.fout     = 1'b1;
          cmd.clr_row  = 1'b1;
          cmd.clr_loss = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

[hdl/mhlg_dp.sv]
// datapath: row buffer, sums, shared multiplier, settings and result register
module mhlg_dp #(
  parameter int MAX_CLASSES = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mhlg_pkg::dp_cmd_t                       cmd,
  output mhlg_pkg::dp_sts_t                       sts,
  input  logic signed [mhlg_pkg::SCORE_W-1:0]     in_score,
  input  logic                                    in_is_true,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [mhlg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [mhlg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mhlg_pkg::GRAD_W-1:0]      out_gradient,
  output logic        [mhlg_pkg::CIDX_W-1:0]      out_class_index,
  output logic        [mhlg_pkg::MEAN_W-1:0]      out_mean_loss,
  output logic                                    out_loss_valid,
  output logic                                    out_last
);
  import mhlg_pkg::*;

  localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CW = $clog2(MAX_CLASSES + 1);

  // row buffer: truth flag above the score
  logic [SCORE_W:0] mem [MAX_CLASSES];
  logic [SCORE_W:0] rd_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  logic [CW-1:0]              fill_r, fill_nxt;
  logic [CW-1:0]              ra_r, ra_nxt;
  logic [CW-1:0]              hits_r, hits_nxt;
  logic signed [TSUM_W-1:0]   tsum_r, tsum_nxt;
  logic [LOSS_W-1:0]          loss_r, loss_nxt;
  logic [PROD_W-1:0]          prod_r;
  logic [RECIP_W-1:0]         acc_r;
  logic [MEAN_W-1:0]          mean_r;
  logic [DELTA_W-1:0]         delta_r;
  logic [RECIP_W-1:0]         recip_r;
  logic                       fwd_r;

  logic                       has_room;
  logic                       ra_done;
  logic                       ev;
  logic signed [SCORE_W-1:0]  rd_score;
  logic                       rd_truth;
  logic signed [MARGIN_W-1:0] margin;
  logic                       pos;
  logic [LOSS_W:0]            loss_sum;
  logic [MUL_A_W-1:0]         mul_a;
  logic [RECIP_W+16:0]        rnd;
  logic [PROD_W:0]            mean_sum;
  logic signed [GRAD_W-1:0]   gmag;
  logic signed [GRAD_W-1:0]   grad;
  logic [CW-1:0]              ra_m1;
  logic [CW+CIDX_W-1:0]       idx_ext;

  assign cfg_ready = 1'b1;

  assign has_room = (fill_r < CW'(MAX_CLASSES));
  assign ra_done  = (ra_r == fill_r);
  assign ev       = cmd.mrg_step && (ra_r != '0);

  assign rd_score = rd_r[SCORE_W-1:0];
  assign rd_truth = rd_r[SCORE_W];
  assign margin   = MARGIN_W'(rd_score) - MARGIN_W'(tsum_r) + MARGIN_W'(delta_r);
  assign pos      = !rd_truth && !margin[MARGIN_W-1] && (margin != '0);
  assign loss_sum = {1'b0, loss_r} + (LOSS_W+1)'(margin);

  assign sts.ra_done  = ra_done;
  assign sts.out_free = !out_valid || !out_stall;
  assign sts.fwd      = fwd_r;

  // settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_RESET;
      recip_r <= RECIP_RESET;
      fwd_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MARGIN_DELTA: delta_r <= cfg_data[DELTA_W-1:0];
        CFG_BATCH_RECIP:  recip_r <= cfg_data[RECIP_W-1:0];
        CFG_FORWARD_ONLY: fwd_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // row buffer
  assign rd_en   = (cmd.mrg_step && !ra_done) || cmd.rd_first || (cmd.emit && !ra_done);
  assign rd_addr = cmd.rd_first ? '0 : ra_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      mem[fill_r[AW-1:0]] <= {in_is_true, in_score};
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    tsum_nxt = tsum_r;
    ra_nxt   = ra_r;
    hits_nxt = hits_r;
    loss_nxt = loss_r;
    if (cmd.load && has_room) begin
      fill_nxt = fill_r + 1'b1;
      if (in_is_true) begin
        tsum_nxt = tsum_r + TSUM_W'(in_score);
      end
    end
    if (ev && pos) begin
      hits_nxt = hits_r + 1'b1;
      loss_nxt = loss_sum[LOSS_W] ? '1 : loss_sum[LOSS_W-1:0];
    end
    if (cmd.rd_first) begin
      ra_nxt = CW'(1);
    end else if (rd_en) begin
      ra_nxt = ra_r + 1'b1;
    end
    if (cmd.clr_row) begin
      fill_nxt = '0;
      tsum_nxt = '0;
      ra_nxt   = '0;
      hits_nxt = '0;
    end
    if (cmd.clr_loss) begin
      loss_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      tsum_r <= '0;
      ra_r   <= '0;
      hits_r <= '0;
      loss_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      tsum_r <= tsum_nxt;
      ra_r   <= ra_nxt;
      hits_r <= hits_nxt;
      loss_r <= loss_nxt;
    end
  end

  // shared multiplier: low and high halves of the loss sum, then hit count
  always_comb begin
    case (cmd.mul_sel)
      MUL_LO:   mul_a = MUL_A_W'(loss_r[15:0]);
      MUL_HI:   mul_a = loss_r[LOSS_W-1:16];
      MUL_HITS: mul_a = MUL_A_W'(hits_r);
      default:  mul_a = '0;
    endcase
  end

  // low partial product stays below 2^33, rounded half up at bit 16
  assign rnd      = {1'b0, prod_r[RECIP_W+15:0]} + (RECIP_W+17)'(32768);
  assign mean_sum = {1'b0, prod_r} + (PROD_W+1)'(acc_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(recip_r);
    end
    if (cmd.acc_en) begin
      acc_r <= rnd[RECIP_W+15:16];
    end
    if (cmd.mean_en) begin
      mean_r <= (mean_sum[PROD_W:MEAN_W] != '0) ? '1 : mean_sum[MEAN_W-1:0];
    end
  end

  // gradient of the entry held in the read register
  assign gmag    = prod_r[GRAD_W-1:0];
  assign grad    = rd_truth ? -gmag : (pos ? GRAD_W'(recip_r) : '0);
  assign ra_m1   = ra_r - 1'b1;
  assign idx_ext = {{CIDX_W{1'b0}}, ra_m1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.fout) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_gradient    <= grad;
      out_class_index <= idx_ext[CIDX_W-1:0];
      out_loss_valid  <= ra_done && cmd.batch;
      out_mean_loss   <= (ra_done && cmd.batch) ? mean_r : '0;
      out_last        <= ra_done;
    end else if (cmd.fout) begin
      out_gradient    <= '0;
      out_class_index <= '0;
      out_loss_valid  <= 1'b1;
      out_mean_loss   <= mean_r;
      out_last        <= 1'b1;
    end
  end

endmodule

[hdl/multiclass_hinge_loss_grad.sv]
// top level of the multiclass hinge loss and gradient block
// Scores of a row are taken one per cycle into a row buffer of MAX_CLASSES
// entries; at the row end the block stops taking scores, runs a margin pass
// over the buffer (one entry per cycle, paced by the single registered read
// port of the buffer), then at a batch end the mean loss arithmetic (low half,
// high half, sum) on the one shared multiplier; in backward mode it forms the
// negative gradient and emits one gradient per cycle while the result side
// takes them. Scores past MAX_CLASSES in a row are dropped, but their row and
// batch marks still close the row. The mean loss rides on the last result of
// the batch; settings must be written only while the block is idle, which the
// block itself does not enforce.
module multiclass_hinge_loss_grad #(
  parameter int MAX_CLASSES = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [mhlg_pkg::SCORE_W-1:0]     in_score,
  input  logic                                    in_is_true,
  input  logic                                    in_row_end,
  input  logic                                    in_batch_end,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mhlg_pkg::GRAD_W-1:0]      out_gradient,
  output logic        [mhlg_pkg::CIDX_W-1:0]      out_class_index,
  output logic        [mhlg_pkg::MEAN_W-1:0]      out_mean_loss,
  output logic                                    out_loss_valid,
  output logic                                    out_last,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [mhlg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [mhlg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mhlg_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mhlg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_row_end   (in_row_end),
    .in_batch_end (in_batch_end),
    .sts          (sts),
    .cmd          (cmd),
    .in_stall     (in_stall)
  );

  mhlg_dp #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_score        (in_score),
    .in_is_true      (in_is_true),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_gradient    (out_gradient),
    .out_class_index (out_class_index),
    .out_mean_loss   (out_mean_loss),
    .out_loss_valid  (out_loss_valid),
    .out_last        (out_last)
  );

endmodule

[tb/multiclass_hinge_loss_grad_test.sv]
// self-checking testbench of the multiclass hinge loss and gradient block
`timescale 1ns / 1ps

module multiclass_hinge_loss_grad_test;
  import mhlg_pkg::*;

  localparam int MAX_CLASSES    = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 300;

  localparam logic [63:0] LOSS_MAX = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MEAN_MAX = 64'h0000_00FF_FFFF_FFFF;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      is_true;
    logic                      row_end;
    logic                      batch_end;
  } score_item_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic [CIDX_W-1:0]        class_index;
    logic [MEAN_W-1:0]        mean_loss;
    logic                     loss_valid;
    logic                     last;
  } grad_result_t;

  // one stimulus row; typed rows carry their own gradient and mean loss
  typedef struct packed {
    score_item_t              item;
    logic                     typed;
    logic signed [GRAD_W-1:0] grad;
    logic [MEAN_W-1:0]        mean;
  } dir_row_t;

  logic                        clk;
  logic                        rst_n        = 1'b0;
  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic signed [SCORE_W-1:0]   in_score     = '0;
  logic                        in_is_true   = 1'b0;
  logic                        in_row_end   = 1'b0;
  logic                        in_batch_end = 1'b0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic signed [GRAD_W-1:0]    out_gradient;
  logic [CIDX_W-1:0]           out_class_index;
  logic [MEAN_W-1:0]           out_mean_loss;
  logic                        out_loss_valid;
  logic                        out_last;
  logic                        cfg_valid    = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index    = '0;
  logic [CFG_DATA_W-1:0]       cfg_data     = '0;

  multiclass_hinge_loss_grad #(
    .MAX_CLASSES(MAX_CLASSES)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_score       (in_score),
    .in_is_true     (in_is_true),
    .in_row_end     (in_row_end),
    .in_batch_end   (in_batch_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gradient   (out_gradient),
    .out_class_index(out_class_index),
    .out_mean_loss  (out_mean_loss),
    .out_loss_valid (out_loss_valid),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // predictor state and settings
  logic signed [SCORE_W-1:0] row_score [MAX_CLASSES];
  logic                      row_truth [MAX_CLASSES];
  int unsigned               row_fill   = 0;
  longint                    true_sum   = 0;
  logic [63:0]               loss_acc   = '0;
  logic [DELTA_W-1:0]        delta_reg  = DELTA_RESET;
  logic [RECIP_W-1:0]        recip_reg  = RECIP_RESET;
  logic                      fwd_reg    = 1'b0;

  grad_result_t pending_grads[$];
  dir_row_t     directed_tab[$];
  int           fail_count  = 0;
  bit           idle_on     = 1'b1;
  int           hold_ticket = 0;
  int           hold_served = 0;
  int           stall_left  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (!idle_on || sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3, 4: return SCORE_W'($urandom);
      default: return SCORE_W'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  function automatic dir_row_t mk_row(input int score, input bit t, input bit re, input bit be,
                                      input bit typed = 1'b0, input int grad = 0,
                                      input longint mean = 0);
    dir_row_t r;
    r = '0;
    r.item.score     = score[SCORE_W-1:0];
    r.item.is_true   = t;
    r.item.row_end   = re;
    r.item.batch_end = be;
    r.typed          = typed;
    r.grad           = grad[GRAD_W-1:0];
    r.mean           = mean[MEAN_W-1:0];
    return r;
  endfunction

  // hinge margins, loss sum and gradients for one accepted score
  function automatic void predict_hinge(input score_item_t it, ref grad_result_t res[$]);
    logic         hit [MAX_CLASSES];
    longint       margin;
    longint       g;
    logic [63:0]  m;
    logic [63:0]  mean;
    int unsigned  hits;
    grad_result_t r;
    res.delete();
    hits = 0;
    if (row_fill < MAX_CLASSES) begin
      row_score[row_fill] = it.score;
      row_truth[row_fill] = it.is_true;
      if (it.is_true) true_sum += longint'(it.score);
      row_fill++;
    end
    // batch end closes the row as well
    if (!(it.row_end || it.batch_end)) return;
    for (int i = 0; i < row_fill; i++) begin
      margin = longint'(row_score[i]) - true_sum + longint'(delta_reg);
      hit[i] = !row_truth[i] && (margin > 0);
      if (hit[i]) begin
        hits++;
        m = margin;
        loss_acc = (LOSS_MAX - loss_acc < m) ? LOSS_MAX : loss_acc + m;
      end
    end
    if (!fwd_reg) begin
      for (int i = 0; i < row_fill; i++) begin
        g = 0;
        if (row_truth[i]) g = -longint'(hits) * longint'(recip_reg);
        else if (hit[i]) g = longint'(recip_reg);
        if (g > 8388607) g = 8388607;
        if (g < -8388608) g = -8388608;
        r = '0;
        r.gradient    = g[GRAD_W-1:0];
        r.class_index = i[CIDX_W-1:0];
        res.push_back(r);
      end
    end
    row_fill = 0;
    true_sum = 0;
    if (it.batch_end) begin
      if (res.size() == 0) res.push_back(grad_result_t'('0));
      // rounded at bit 16, split to keep the product inside 64 bits
      mean = (loss_acc >> 16) * recip_reg
             + ((({48'd0, loss_acc[15:0]}) * recip_reg + 64'd32768) >> 16);
      if (mean > MEAN_MAX) mean = MEAN_MAX;
      r = res.pop_back();
      r.mean_loss  = mean[MEAN_W-1:0];
      r.loss_valid = 1'b1;
      res.push_back(r);
      loss_acc = '0;
    end
    if (res.size() > 0) begin
      r = res.pop_back();
      r.last = 1'b1;
      res.push_back(r);
    end
  endfunction

  task automatic offer_row(input dir_row_t row);
    grad_result_t res[$];
    grad_result_t typed_res;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_score     <= row.item.score;
    in_is_true   <= row.item.is_true;
    in_row_end   <= row.item.row_end;
    in_batch_end <= row.item.batch_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_hinge(row.item, res);
    if (row.typed) begin
      typed_res = '{gradient: row.grad, class_index: '0, mean_loss: row.mean,
                    loss_valid: 1'b1, last: 1'b1};
      pending_grads.push_back(typed_res);
    end else begin
      foreach (res[k]) pending_grads.push_back(res[k]);
    end
  endtask

  task automatic wait_idle();
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [DELTA_W-1:0] delta,
                                input logic [RECIP_W-1:0] recip, input logic fwd);
    logic [CFG_IDX_W-1:0]  idx_list [3];
    logic [CFG_DATA_W-1:0] val_list [3];
    idx_list = '{CFG_MARGIN_DELTA, CFG_BATCH_RECIP, CFG_FORWARD_ONLY};
    val_list = '{CFG_DATA_W'(delta), CFG_DATA_W'(recip), CFG_DATA_W'(fwd)};
    wait_idle();
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data  <= val_list[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    delta_reg = delta;
    recip_reg = recip;
    fwd_reg   = fwd;
  endtask

  // mostly well-formed batches with random content, some noise in between
  task automatic random_phase(input int item_target, input int batch_floor,
                              input bit short_rows);
    dir_row_t row;
    int items;
    int batches;
    int rows;
    int len;
    int sel;
    int true_at;
    bit no_true;
    items   = 0;
    batches = 0;
    while (items < item_target || batches < batch_floor) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          row = '0;
          row.item.score     = SCORE_W'($urandom);
          row.item.is_true   = 1'($urandom_range(0, 1));
          row.item.row_end   = 1'($urandom_range(0, 1));
          row.item.batch_end = ($urandom_range(0, 3) == 0);
          offer_row(row);
          items++;
        end
      end
      rows = short_rows ? $urandom_range(1, 2) : $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) len = $urandom_range(17, 20);
        else if (sel < 3) len = $urandom_range(7, 16);
        else len = short_rows ? $urandom_range(1, 4) : $urandom_range(1, 6);
        true_at = $urandom_range(0, len - 1);
        no_true = ($urandom_range(0, 9) == 0);
        for (int c = 0; c < len; c++) begin
          row = '0;
          row.item.score   = rand_score();
          row.item.is_true = (c == true_at && !no_true) || ($urandom_range(0, 9) == 0);
          row.item.row_end = (c == len - 1);
          if (c == len - 1 && r == rows - 1) begin
            row.item.batch_end = 1'b1;
            if ($urandom_range(0, 3) == 0) row.item.row_end = 1'b0;
          end
          offer_row(row);
          items++;
        end
      end
      batches++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    grad_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grads.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none actual gradient %0d index %0d",
                 $time, out_gradient, out_class_index);
      end else begin
        want = pending_grads.pop_front();
        check_field("gradient", longint'($signed(want.gradient)), longint'(out_gradient));
        check_field("class_index", longint'(want.class_index), longint'(out_class_index));
        check_field("mean_loss", longint'(want.mean_loss), longint'(out_mean_loss));
        check_field("loss_valid", longint'(want.loss_valid), longint'(out_loss_valid));
        check_field("last", longint'(want.last), longint'(out_last));
      end
    end
  end

  // result side: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin : result_sink
    if (hold_served != hold_ticket) begin
      hold_served = hold_ticket;
      stall_left  = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    directed_tab = '{
      mk_row(32767, 1'b1, 1'b0, 1'b1, 1'b1, 0, 0),        // lone true class, no row end
      mk_row(32767, 1'b0, 1'b1, 1'b1, 1'b1, 65536, 32818),
      mk_row(-32768, 1'b0, 1'b1, 1'b1, 1'b1, 0, 0),
      mk_row(0, 1'b0, 1'b1, 1'b1, 1'b1, 65536, 51),
      mk_row(100, 1'b1, 1'b0, 1'b0),                      // two true classes in this row
      mk_row(50, 1'b0, 1'b0, 1'b0),
      mk_row(200, 1'b0, 1'b0, 1'b0),
      mk_row(-500, 1'b1, 1'b1, 1'b0),
      mk_row(10, 1'b0, 1'b0, 1'b0),                       // no true class at all
      mk_row(-60, 1'b0, 1'b0, 1'b1)
    };
    // overflowing row: the seventeenth score is dropped, its marks still close
    for (int k = 0; k < MAX_CLASSES + 1; k++)
      directed_tab.push_back(mk_row(k * 3000 - 24000, (k == 3 || k == MAX_CLASSES),
                                    (k == MAX_CLASSES), (k == MAX_CLASSES)));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tab[k]) offer_row(directed_tab[k]);
    in_valid <= 1'b0;

    apply_settings('0, '0, 1'b0);
    random_phase(70, 0, 1'b0);

    apply_settings(15'h7FFF, 17'd65536, 1'b1);
    random_phase(60, 6, 1'b1);

    // back to back with the result side held off, so the block backs up
    apply_settings(DELTA_W'($urandom), RECIP_W'($urandom_range(1, 65536)), 1'b0);
    idle_on = 1'b0;
    hold_ticket <= hold_ticket + 1;
    random_phase(70, 0, 1'b0);
    idle_on = 1'b1;

    apply_settings(DELTA_W'($urandom_range(0, 255)), 17'd1, 1'b1);
    random_phase(60, 6, 1'b1);

    apply_settings(DELTA_RESET, 17'd21845, 1'b0);
    random_phase(70, 0, 1'b0);

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
